@@ design/tscr_pkg.sv @@
// ----------------------------------------------------------------------------
// tscr_pkg
// Shared types and constants of the three-shunt current reconstruction block.
// ----------------------------------------------------------------------------
package tscr_pkg;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_UPDATE = 2'd1;
   localparam logic [1:0] OP_CSTART = 2'd2;
   localparam logic [1:0] OP_CTICK  = 2'd3;

   localparam logic [1:0] CPH_IDLE = 2'd0;
   localparam logic [1:0] CPH_AB   = 2'd1;
   localparam logic [1:0] CPH_C    = 2'd2;

   localparam logic [1:0] REG_GAIN_A = 2'd0;
   localparam logic [1:0] REG_GAIN_B = 2'd1;
   localparam logic [1:0] REG_GAIN_C = 2'd2;
   localparam logic [1:0] REG_TICKS  = 2'd3;

   localparam logic [15:0] OFFSET_RESET = 16'd32768;
   localparam logic [15:0] GAIN_RESET   = 16'd27500;
   localparam logic [7:0]  TICK_RESET   = 8'd25;
   localparam logic [2:0]  SECTOR_RESET = 3'd3;
   localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

   // Commands from controller to datapath.
   typedef struct packed {
      logic       exec;      // apply the accepted request
      logic       div_start; // load divider
      logic       div_step;  // one quotient bit
      logic [1:0] div_sel;   // 0 phase A, 1 phase B, 2 phase C
      logic       div_write; // store quotient into offset
   } tscr_cmd_type;

   typedef struct packed {
      logic       end_ab;    // tick ends phase A/B
      logic       end_c;     // tick ends phase C
      logic       have_cnt;  // sample count nonzero
   } tscr_stat_type;

   function automatic logic [3:0] chan1(input logic [2:0] s);
      case (s)
         3'd0, 3'd5: chan1 = 4'd8;
         default:    chan1 = 4'd7;
      endcase
   endfunction

   function automatic logic [3:0] chan2(input logic [2:0] s);
      case (s)
         3'd3, 3'd4: chan2 = 4'd8;
         default:    chan2 = 4'd9;
      endcase
   endfunction

endpackage

@@ design/tscr_ctrl.sv @@
// ----------------------------------------------------------------------------
// tscr_ctrl
// Sequencer: handshake, one execute cycle, then bit-serial divide passes on phase end.
// ----------------------------------------------------------------------------
module tscr_ctrl #(
   parameter int SUM_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [1:0]              opcode,
   input  tscr_pkg::tscr_stat_type stat,
   output tscr_pkg::tscr_cmd_type  cmd
);

   localparam int CW = $clog2(SUM_BITS + 1);

   typedef enum logic [2:0] {S_IDLE, S_DLOAD, S_DRUN, S_DWR, S_OUT} state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [1:0]       sel_ff, sel_in;
   logic             last_ff, last_in;   // final phase to divide
   logic             ab_ff, ab_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      last_in  = last_ff;
      ab_in    = ab_ff;
      cmd      = '0;
      cmd.div_sel = sel_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.exec = 1'b1;
               state_in = S_OUT;
               if (opcode == tscr_pkg::OP_CTICK && stat.have_cnt &&
                   (stat.end_ab || stat.end_c)) begin
                  // exec stores results except offsets; divide follows
                  state_in = S_DLOAD;
                  ab_in    = stat.end_ab;
                  sel_in   = stat.end_ab ? 2'd0 : 2'd2;
                  last_in  = !stat.end_ab;
               end
            end
         end
         S_DLOAD: begin
            cmd.div_start = 1'b1;
            cnt_in   = CW'(SUM_BITS);
            state_in = S_DRUN;
         end
         S_DRUN: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) state_in = S_DWR;
         end
         S_DWR: begin
            cmd.div_write = 1'b1;
            if (last_ff) begin
               state_in = S_OUT;
            end else begin
               sel_in   = 2'd1;
               last_in  = 1'b1;
               state_in = S_DLOAD;
            end
         end
         S_OUT: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         sel_ff   <= '0;
         last_ff  <= 1'b0;
         ab_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
         last_ff  <= last_in;
         ab_ff    <= ab_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT) && !ab_ff || (state_ff == S_OUT) && ab_ff;

endmodule

@@ design/tscr_dp.sv @@
// ----------------------------------------------------------------------------
// tscr_dp
// Datapath: sector buffers, current math, calibration sums, offset divider.
// ----------------------------------------------------------------------------
module tscr_dp #(
   parameter int SAMPLE_BITS = 16,
   parameter int SUM_BITS    = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tscr_pkg::tscr_cmd_type  cmd,
   output tscr_pkg::tscr_stat_type stat,
   input  logic [1:0]              opcode,
   input  logic [15:0]             adc1_sample,
   input  logic [15:0]             adc2_sample,
   input  logic [2:0]              new_sector,
   input  logic [15:0]             gain_a,
   input  logic [15:0]             gain_b,
   input  logic [15:0]             gain_c,
   input  logic [7:0]              tick_limit,
   output logic signed [15:0]      phase_cur_a,
   output logic signed [15:0]      phase_cur_b,
   output logic signed [15:0]      phase_cur_c,
   output logic signed [15:0]      milliamp_a,
   output logic signed [15:0]      milliamp_b,
   output logic signed [15:0]      milliamp_c,
   output logic [15:0]             raw_a,
   output logic [15:0]             raw_b,
   output logic [15:0]             raw_c,
   output logic [3:0]              chan1,
   output logic [3:0]              chan2,
   output logic [1:0]              status
);

   logic [2:0]  act_ff, pend_ff, force_ff;
   logic [15:0] off_ff [3];
   logic [1:0]  cph_ff;
   logic [7:0]  ticks_ff;
   logic [15:0] cnt_ff;
   logic [SUM_BITS-1:0] sum_ff [3];
   logic        calf_ff;
   logic signed [15:0] cur_ff [3];
   logic [15:0] raw_ff [3];
   logic [3:0]  ch1_ff, ch2_ff;
   logic signed [33:0] pa, pb, pc;

   // divider
   logic [SUM_BITS-1:0] quo_ff, dvd_ff;
   logic [16:0]         rem_ff;
   logic [17:0]         trial;

   logic [15:0] s1, s2;
   logic [7:0]  tick_nx;
   logic signed [17:0] ia, ib, ic;
   logic signed [17:0] oa, ob, oc, x1, x2;
   logic [2:0]  sreq, snew;

   function automatic logic signed [15:0] sat(input logic signed [17:0] v);
      if (v > 18'sd32767)       sat = 16'sd32767;
      else if (v < -18'sd32767) sat = -16'sd32767;
      else                      sat = v[15:0];
   endfunction

   always_comb begin
      s1 = 16'(adc1_sample & 16'((17'd1 << SAMPLE_BITS) - 17'd1));
      s2 = 16'(adc2_sample & 16'((17'd1 << SAMPLE_BITS) - 17'd1));
      tick_nx = ticks_ff + 8'd1;
      stat.end_ab  = (cph_ff == tscr_pkg::CPH_AB) && (tick_nx >= tick_limit);
      stat.end_c   = (cph_ff == tscr_pkg::CPH_C)  && (tick_nx >= tick_limit);
      stat.have_cnt = (cnt_ff != 16'd0);
      oa = 18'(off_ff[0]); ob = 18'(off_ff[1]); oc = 18'(off_ff[2]);
      x1 = 18'(s1); x2 = 18'(s2);
      if (act_ff == 3'd3 || act_ff == 3'd4) begin
         ia = 18'(sat(oa - x1));
         ib = 18'(sat(ob - x2));
      end else if (act_ff == 3'd5 || act_ff == 3'd0) begin
         ib = 18'(sat(ob - x1));
         ia = 18'(sat(x2 - oc - ib));
      end else begin
         ia = 18'(sat(oa - x1));
         ib = 18'(sat(x2 - oc - ia));
      end
      ic = 18'(sat(-ia - ib));
      sreq = (new_sector > 3'd5) ? 3'd5 : new_sector;
      snew = (cph_ff != tscr_pkg::CPH_IDLE) ? force_ff : sreq;
      if (snew > 3'd5) snew = 3'd5;
      trial = {rem_ff, dvd_ff[SUM_BITS-1]} - {2'b0, cnt_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff   <= tscr_pkg::SECTOR_RESET;
         pend_ff  <= tscr_pkg::SECTOR_RESET;
         force_ff <= tscr_pkg::SECTOR_RESET;
         for (int i = 0; i < 3; i++) begin
            off_ff[i] <= tscr_pkg::OFFSET_RESET;
            sum_ff[i] <= '0;
            cur_ff[i] <= '0;
            raw_ff[i] <= '0;
         end
         cph_ff   <= tscr_pkg::CPH_IDLE;
         ticks_ff <= '0;
         cnt_ff   <= '0;
         calf_ff  <= 1'b0;
         ch1_ff   <= 4'd7;
         ch2_ff   <= 4'd8;
      end else begin
         if (cmd.exec) begin
            case (opcode)
               tscr_pkg::OP_SAMPLE: begin
                  if (cph_ff != tscr_pkg::CPH_IDLE) begin
                     if (cph_ff == tscr_pkg::CPH_AB) begin
                        sum_ff[0] <= sum_ff[0] + SUM_BITS'(s1);
                        sum_ff[1] <= sum_ff[1] + SUM_BITS'(s2);
                     end else begin
                        sum_ff[2] <= sum_ff[2] + SUM_BITS'(s2);
                     end
                     if (cnt_ff != tscr_pkg::COUNT_MAX) cnt_ff <= cnt_ff + 16'd1;
                  end else begin
                     cur_ff[0] <= ia[15:0];
                     cur_ff[1] <= ib[15:0];
                     cur_ff[2] <= ic[15:0];
                     raw_ff[0] <= (act_ff == 3'd5 || act_ff == 3'd0) ? 16'd0 : s1;
                     raw_ff[1] <= (act_ff == 3'd3 || act_ff == 3'd4) ? s2 :
                                  (act_ff == 3'd5 || act_ff == 3'd0) ? s1 : 16'd0;
                     raw_ff[2] <= (act_ff == 3'd3 || act_ff == 3'd4) ? 16'd0 : s2;
                  end
               end
               tscr_pkg::OP_UPDATE: begin
                  ch1_ff  <= tscr_pkg::chan1(snew);
                  ch2_ff  <= tscr_pkg::chan2(snew);
                  act_ff  <= pend_ff;
                  pend_ff <= snew;
               end
               tscr_pkg::OP_CSTART: begin
                  cph_ff   <= tscr_pkg::CPH_AB;
                  ticks_ff <= '0;
                  cnt_ff   <= '0;
                  for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
                  force_ff <= 3'd4;
               end
               default: begin
                  if (cph_ff != tscr_pkg::CPH_IDLE) begin
                     ticks_ff <= tick_nx;
                     if (stat.end_ab) begin
                        cph_ff   <= tscr_pkg::CPH_C;
                        ticks_ff <= '0;
                        force_ff <= 3'd0;
                     end else if (stat.end_c) begin
                        cph_ff   <= tscr_pkg::CPH_IDLE;
                        ticks_ff <= '0;
                        calf_ff  <= 1'b1;
                     end
                  end
               end
            endcase
         end
         // after the phase B quotient is stored, the count and the phase C sum are cleared
         if (cmd.div_write) begin
            off_ff[cmd.div_sel] <= quo_ff[15:0];
            if (cmd.div_sel == 2'd1) begin
               cnt_ff    <= '0;
               sum_ff[2] <= '0;
            end
         end
      end
   end

   // Restoring divider, one quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dvd_ff <= sum_ff[cmd.div_sel];
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= dvd_ff << 1;
         if (!trial[17]) begin
            rem_ff <= trial[16:0];
            quo_ff <= {quo_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[15:0], dvd_ff[SUM_BITS-1]};
            quo_ff <= {quo_ff[SUM_BITS-2:0], 1'b0};
         end
      end
   end

   // Milliamp products, taken straight from the latched currents.
   always_comb begin
      pa = 34'(cur_ff[0]) * $signed({18'd0, gain_a});
      pb = 34'(cur_ff[1]) * $signed({18'd0, gain_b});
      pc = 34'(cur_ff[2]) * $signed({18'd0, gain_c});
   end

   assign phase_cur_a = cur_ff[0];
   assign phase_cur_b = cur_ff[1];
   assign phase_cur_c = cur_ff[2];
   assign milliamp_a  = pa[31:16];
   assign milliamp_b  = pb[31:16];
   assign milliamp_c  = pc[31:16];
   assign raw_a       = raw_ff[0];
   assign raw_b       = raw_ff[1];
   assign raw_c       = raw_ff[2];
   assign chan1       = ch1_ff;
   assign chan2       = ch2_ff;
   assign status      = (cph_ff != tscr_pkg::CPH_IDLE) ? 2'd1 : (calf_ff ? 2'd2 : 2'd0);

endmodule

@@ design/three_shunt_current_reconstruct_core.sv @@
// Response: valid the cycle after a request is accepted, except that a
// calibration tick that closes a phase with samples first runs the divider
// states DLOAD, DRUN, DWR for each offset (two for phase A/B, one for phase C).
// Throughput: one request at a time; next request accepted after the response.
// Reset: synchronous, active high; restores sectors, offsets, gains, status.
// ----------------------------------------------------------------------------
// three_shunt_current_reconstruct_core
// Three-shunt motor phase current reconstruction with offset calibration.
// ----------------------------------------------------------------------------
module three_shunt_current_reconstruct_core #(
   parameter int SAMPLE_BITS = 16,
   parameter int SUM_BITS    = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic [15:0]        req_adc1_sample,
   input  logic [15:0]        req_adc2_sample,
   input  logic [2:0]         req_new_sector,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_phase_cur_a,
   output logic signed [15:0] rsp_phase_cur_b,
   output logic signed [15:0] rsp_phase_cur_c,
   output logic signed [15:0] rsp_milliamp_a,
   output logic signed [15:0] rsp_milliamp_b,
   output logic signed [15:0] rsp_milliamp_c,
   output logic [15:0]        rsp_raw_phase_a,
   output logic [15:0]        rsp_raw_phase_b,
   output logic [15:0]        rsp_raw_phase_c,
   output logic [3:0]         rsp_adc1_channel,
   output logic [3:0]         rsp_adc2_channel,
   output logic [1:0]         rsp_calib_status,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   tscr_pkg::tscr_cmd_type  cmd;
   tscr_pkg::tscr_stat_type stat;

   // Configuration registers: gains and calibration tick limit.
   logic [15:0] gain_a_ff, gain_b_ff, gain_c_ff;
   logic [7:0]  tick_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_a_ff <= tscr_pkg::GAIN_RESET;
         gain_b_ff <= tscr_pkg::GAIN_RESET;
         gain_c_ff <= tscr_pkg::GAIN_RESET;
         tick_ff   <= tscr_pkg::TICK_RESET;
      end else if (wr_en && paddr[1:0] == 2'b00) begin
         case (paddr[3:2])
            tscr_pkg::REG_GAIN_A: gain_a_ff <= pwdata[15:0];
            tscr_pkg::REG_GAIN_B: gain_b_ff <= pwdata[15:0];
            tscr_pkg::REG_GAIN_C: gain_c_ff <= pwdata[15:0];
            tscr_pkg::REG_TICKS:  tick_ff   <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register.
   always_comb begin
      case (paddr[3:2])
         tscr_pkg::REG_GAIN_A: prdata = {16'd0, gain_a_ff};
         tscr_pkg::REG_GAIN_B: prdata = {16'd0, gain_b_ff};
         tscr_pkg::REG_GAIN_C: prdata = {16'd0, gain_c_ff};
         tscr_pkg::REG_TICKS:  prdata = {24'd0, tick_ff};
         default:              prdata = '0;
      endcase
   end

   // Sequencer: accept, execute, divide on phase end, hold response.
   tscr_ctrl #(.SUM_BITS(SUM_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .opcode    (req_opcode),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: state registers, current math, calibration and divider.
   tscr_dp #(.SAMPLE_BITS(SAMPLE_BITS), .SUM_BITS(SUM_BITS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .opcode      (req_opcode),
      .adc1_sample (req_adc1_sample),
      .adc2_sample (req_adc2_sample),
      .new_sector  (req_new_sector),
      .gain_a      (gain_a_ff),
      .gain_b      (gain_b_ff),
      .gain_c      (gain_c_ff),
      .tick_limit  (tick_ff),
      .phase_cur_a (rsp_phase_cur_a),
      .phase_cur_b (rsp_phase_cur_b),
      .phase_cur_c (rsp_phase_cur_c),
      .milliamp_a  (rsp_milliamp_a),
      .milliamp_b  (rsp_milliamp_b),
      .milliamp_c  (rsp_milliamp_c),
      .raw_a       (rsp_raw_phase_a),
      .raw_b       (rsp_raw_phase_b),
      .raw_c       (rsp_raw_phase_c),
      .chan1       (rsp_adc1_channel),
      .chan2       (rsp_adc2_channel),
      .status      (rsp_calib_status)
   );

`ifndef ASSERT_OFF
   // A request is never taken while a response is still pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request accepted during response");

   // The datapath executes only on an accepted request.
   a_exec_acc: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> (req_valid && req_ready)) else $error("execute without request");

   // Divider never starts and steps at once.
   a_div: assert property (@(posedge clock) disable iff (reset)
      !(cmd.div_start && cmd.div_step)) else $error("divider command clash");
`endif

endmodule
